/* src/salc_pkg.sv */
// salc_pkg: shared types and constants of the cache tag store
// request/result payloads, line record, controller command and status
// no dependencies
`timescale 1ns / 1ps

package salc_pkg;

  localparam int ADDR_W     = 32;
  localparam int AGE_W      = 3;
  localparam int CNT_W      = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 5;

  localparam logic [AGE_W-1:0] AGE_MAX = 3'd7;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_WRITE_POLICY = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_BITS  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_INDEX_BITS   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_WAYS_IN_USE  = 2'd3;

  // reference kinds and write policies
  localparam logic MODE_READ   = 1'b0;
  localparam logic MODE_WRITE  = 1'b1;
  localparam logic POLICY_WT   = 1'b0;
  localparam logic POLICY_WB   = 1'b1;

  typedef struct packed {
    logic              mode;
    logic [ADDR_W-1:0] address;
  } req_t;

  typedef struct packed {
    logic             hit;
    logic             dirty_evicted;
    logic [1:0]       accesses_now;
    logic [CNT_W-1:0] hit_total;
    logic [CNT_W-1:0] miss_total;
    logic [CNT_W-1:0] access_total;
  } rsp_t;

  typedef struct packed {
    logic              valid;
    logic              dirty;
    logic [AGE_W-1:0]  age;
    logic [ADDR_W-1:0] tag;
  } line_t;

  localparam int LINE_W = $bits(line_t);

  typedef struct packed {
    logic clear;
    logic accept;
    logic commit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic clear_last;
  } ctrl_sts_t;

endpackage

/* src/salc_ram.sv */
// salc_ram: generic single write port / single read port memory
// read data is registered; no dependencies
`timescale 1ns / 1ps

module salc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic                                     re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* src/salc_ctrl.sv */
// salc_ctrl: sequencer of the cache tag store
// clearing pass, request accept, lookup/commit and result handshake; uses salc_pkg
`timescale 1ns / 1ps

module salc_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  output salc_pkg::ctrl_cmd_t  cmd,
  input  salc_pkg::ctrl_sts_t  sts
);

  typedef enum logic [2:0] {
    ST_CLEAR  = 3'b001,
    ST_IDLE   = 3'b010,
    ST_LOOKUP = 3'b100
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt  = state_r;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state_r)
      ST_CLEAR: begin
        cmd.clear = 1'b1;
        if (sts.clear_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        // hold the row until the result register is free
        if (!out_valid_r || out_ready) begin
          cmd.commit = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  always_comb begin
    if (cmd.commit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

`ifndef NO_ASSERTIONS
  a_no_req_while_clear: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_CLEAR |-> !in_ready && !cmd.commit)
    else $error("request taken during clearing pass");

  a_commit_shows_result: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |=> out_valid_r && state_r == ST_IDLE)
    else $error("commit did not present a result");
`endif

endmodule

/* src/salc_dp.sv */
// salc_dp: datapath of the cache tag store
// config registers, address split, way search, lru update, totals; uses salc_pkg, salc_ram
`timescale 1ns / 1ps

module salc_dp #(
  parameter int SETS = 256,
  parameter int WAYS = 8
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    cfg_we,
  input  logic [salc_pkg::CFG_IDX_W-1:0]          cfg_index,
  input  logic [salc_pkg::CFG_DATA_W-1:0]         cfg_wdata,
  input  salc_pkg::req_t                          in_data,
  output salc_pkg::rsp_t                          out_data,
  input  salc_pkg::ctrl_cmd_t                     cmd,
  output salc_pkg::ctrl_sts_t                     sts
);

  localparam int SET_W = (SETS > 1) ? $clog2(SETS) : 1;
  localparam int WAY_W = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int NW_W  = $clog2(WAYS + 1);
  localparam logic [3:0] MAX_IB = 4'($clog2(SETS + 1) - 1);
  localparam int ROW_W = WAYS * salc_pkg::LINE_W;

  // configuration
  logic       policy_r;
  logic [4:0] offset_bits_r;
  logic [3:0] index_bits_r;
  logic [3:0] ways_in_use_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      policy_r      <= salc_pkg::POLICY_WT;
      offset_bits_r <= 5'd4;
      index_bits_r  <= 4'd0;
      ways_in_use_r <= 4'd1;
    end else if (cfg_we) begin
      case (cfg_index)
        salc_pkg::CFG_WRITE_POLICY: policy_r      <= cfg_wdata[0];
        salc_pkg::CFG_OFFSET_BITS:  offset_bits_r <= cfg_wdata[4:0];
        salc_pkg::CFG_INDEX_BITS:   index_bits_r  <= cfg_wdata[3:0];
        salc_pkg::CFG_WAYS_IN_USE:  ways_in_use_r <= cfg_wdata[3:0];
        default: ;
      endcase
    end
  end

  // address split at accept
  logic [3:0]                  ib_eff;
  logic [5:0]                  tag_shift;
  logic [salc_pkg::ADDR_W-1:0] idx_field;
  logic [salc_pkg::ADDR_W-1:0] idx_mask;
  logic [SET_W-1:0]            idx_in;
  logic [salc_pkg::ADDR_W-1:0] tag_in;

  always_comb begin
    ib_eff    = (index_bits_r > MAX_IB) ? MAX_IB : index_bits_r;
    idx_field = in_data.address >> offset_bits_r;
    idx_mask  = ~({salc_pkg::ADDR_W{1'b1}} << ib_eff);
    idx_in    = SET_W'(idx_field & idx_mask);
    tag_shift = {1'b0, offset_bits_r} + {2'b00, ib_eff};
    tag_in    = tag_shift[5] ? '0 : (in_data.address >> tag_shift[4:0]);
  end

  logic [SET_W-1:0]            idx_r;
  logic [salc_pkg::ADDR_W-1:0] tag_r;
  logic                        is_write_r;

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      idx_r      <= idx_in;
      tag_r      <= tag_in;
      is_write_r <= (in_data.mode == salc_pkg::MODE_WRITE);
    end
  end

  // clearing pass counter
  logic [SET_W-1:0] clr_cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
    end else if (cmd.clear) begin
      clr_cnt_r <= clr_cnt_r + SET_W'(1);
    end
  end

  assign sts.clear_last = (clr_cnt_r == SET_W'(SETS - 1));

  // set memory: one row holds all ways
  logic [ROW_W-1:0] row_rdata;
  logic [ROW_W-1:0] row_wdata;
  logic [ROW_W-1:0] new_row_flat;

  salc_ram #(
    .WIDTH (ROW_W),
    .DEPTH (SETS)
  ) u_row_ram (
    .clk   (clk),
    .we    (cmd.clear | cmd.commit),
    .waddr (cmd.clear ? clr_cnt_r : idx_r),
    .wdata (row_wdata),
    .re    (cmd.accept),
    .raddr (idx_in),
    .rdata (row_rdata)
  );

  assign row_wdata = cmd.clear ? '0 : new_row_flat;

  // lookup and update
  salc_pkg::line_t rows    [WAYS];
  salc_pkg::line_t new_row [WAYS];
  logic [WAYS-1:0]  way_en;
  logic [NW_W-1:0]  nw;
  logic             hit;
  logic [WAY_W-1:0] hit_way;
  logic             inv_found;
  logic [WAY_W-1:0] inv_way;
  logic [WAY_W-1:0] lru_way;
  logic [salc_pkg::AGE_W-1:0] lru_age;
  logic [WAY_W-1:0] tgt;
  logic             alloc;
  logic             touch_en;
  logic [3:0]       old_rank;
  logic             dev;
  logic [1:0]       acc;
  logic             wb;

  always_comb begin
    wb = (policy_r == salc_pkg::POLICY_WB);
    if (ways_in_use_r == 4'd0) begin
      nw = NW_W'(1);
    end else if ({1'b0, ways_in_use_r} > 5'(WAYS)) begin
      nw = NW_W'(WAYS);
    end else begin
      nw = NW_W'(ways_in_use_r);
    end
    for (int w = 0; w < WAYS; w++) begin
      rows[w]   = row_rdata[w*salc_pkg::LINE_W +: salc_pkg::LINE_W];
      way_en[w] = (NW_W'(w) < nw);
    end
  end

  // lowest matching way, first invalid way, oldest way
  always_comb begin
    hit       = 1'b0;
    hit_way   = '0;
    inv_found = 1'b0;
    inv_way   = '0;
    lru_way   = '0;
    lru_age   = '0;
    for (int w = 0; w < WAYS; w++) begin
      if (way_en[w] && rows[w].valid && rows[w].tag == tag_r && !hit) begin
        hit     = 1'b1;
        hit_way = WAY_W'(w);
      end
      if (way_en[w] && !rows[w].valid && !inv_found) begin
        inv_found = 1'b1;
        inv_way   = WAY_W'(w);
      end
      if (way_en[w] && rows[w].age > lru_age) begin
        lru_age = rows[w].age;
        lru_way = WAY_W'(w);
      end
    end
  end

  always_comb begin
    alloc    = !hit && (wb || !is_write_r);
    touch_en = hit || alloc;
    if (hit) begin
      tgt = hit_way;
    end else if (inv_found) begin
      tgt = inv_way;
    end else begin
      tgt = lru_way;
    end
    old_rank = rows[tgt].valid ? {1'b0, rows[tgt].age} : 4'd8;
    dev      = alloc && wb && rows[tgt].valid && rows[tgt].dirty;
    if (hit) begin
      acc = (is_write_r && !wb) ? 2'd1 : 2'd0;
    end else begin
      acc = dev ? 2'd2 : 2'd1;
    end
  end

  always_comb begin
    for (int w = 0; w < WAYS; w++) begin
      new_row[w] = rows[w];
      if (touch_en && WAY_W'(w) != tgt && way_en[w] && rows[w].valid &&
          {1'b0, rows[w].age} < old_rank && rows[w].age < salc_pkg::AGE_MAX) begin
        new_row[w].age = rows[w].age + salc_pkg::AGE_W'(1);
      end
      if (touch_en && WAY_W'(w) == tgt) begin
        new_row[w].age = '0;
        if (alloc) begin
          new_row[w].valid = 1'b1;
          new_row[w].tag   = tag_r;
          new_row[w].dirty = wb && is_write_r;
        end else if (is_write_r && wb) begin
          new_row[w].dirty = 1'b1;
        end
      end
      new_row_flat[w*salc_pkg::LINE_W +: salc_pkg::LINE_W] = new_row[w];
    end
  end

  // saturating totals
  logic [salc_pkg::CNT_W-1:0] hits_r, misses_r, accs_r;
  logic [salc_pkg::CNT_W-1:0] hits_nxt, misses_nxt, accs_nxt;
  logic [salc_pkg::CNT_W:0]   hsum, msum, asum;

  always_comb begin
    hsum       = {1'b0, hits_r} + {{salc_pkg::CNT_W{1'b0}}, hit};
    msum       = {1'b0, misses_r} + {{salc_pkg::CNT_W{1'b0}}, !hit};
    asum       = {1'b0, accs_r} + {{(salc_pkg::CNT_W-1){1'b0}}, acc};
    hits_nxt   = hsum[salc_pkg::CNT_W] ? '1 : hsum[salc_pkg::CNT_W-1:0];
    misses_nxt = msum[salc_pkg::CNT_W] ? '1 : msum[salc_pkg::CNT_W-1:0];
    accs_nxt   = asum[salc_pkg::CNT_W] ? '1 : asum[salc_pkg::CNT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hits_r   <= '0;
      misses_r <= '0;
      accs_r   <= '0;
    end else if (cmd.commit) begin
      hits_r   <= hits_nxt;
      misses_r <= misses_nxt;
      accs_r   <= accs_nxt;
    end
  end

  salc_pkg::rsp_t out_r;

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_r.hit           <= hit;
      out_r.dirty_evicted <= dev;
      out_r.accesses_now  <= acc;
      out_r.hit_total     <= hits_nxt;
      out_r.miss_total    <= misses_nxt;
      out_r.access_total  <= accs_nxt;
    end
  end

  assign out_data = out_r;

`ifndef NO_ASSERTIONS
  a_one_count_moves: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |=> (hits_r != $past(hits_r)) || (misses_r != $past(misses_r)) ||
                   (&$past(hits_r)) || (&$past(misses_r)))
    else $error("lookup counted neither hit nor miss");

  a_evict_costs_two: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |=> !out_r.dirty_evicted ||
                   (!out_r.hit && out_r.accesses_now == 2'd2))
    else $error("dirty eviction reported with wrong access count");
`endif

endmodule

/* src/set_assoc_lru_cache_tag_store.sv */
// set_assoc_lru_cache_tag_store: top level of the cache tag store
// joins the sequencer and the datapath; uses salc_pkg, salc_ctrl, salc_dp
`timescale 1ns / 1ps

// Usage:
//   in_valid/in_ready/in_data carry one read or write request (mode, address).
//   out_valid/out_ready/out_data return one result per request: hit,
//   dirty eviction, memory accesses of this request and saturating totals.
//   cfg_we/cfg_index/cfg_wdata write the policy, offset width, index width
//   and ways in use; write only while no request is in flight.
// Operation:
//   a request is taken in the idle state while the set row is read from
//   the set memory; the lookup state then compares all ways, picks the
//   victim, writes the row back and loads the result register, and
//   out_valid is set by that commit. A new request is taken only after
//   the read-modify-write of the set row is done.
// Reset:
//   after rst_n the block sweeps the set memory, one set per cycle, through
//   every set with in_ready low; configuration writes are taken meanwhile.
// Stall:
//   a held result lets one more request be accepted and looked up; its
//   commit waits until the result register is free.
module set_assoc_lru_cache_tag_store #(
  parameter int SETS = 256,
  parameter int WAYS = 8
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  salc_pkg::req_t                  in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output salc_pkg::rsp_t                  out_data,
  input  logic                            cfg_we,
  input  logic [salc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [salc_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  salc_pkg::ctrl_cmd_t cmd;
  salc_pkg::ctrl_sts_t sts;

  salc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  salc_dp #(
    .SETS (SETS),
    .WAYS (WAYS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_data   (in_data),
    .out_data  (out_data),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule
